// ----- rtl/lr_pkg.sv -----
// Package for the line rasterizer: grid constants, the line descriptor
// that travels from the front end to the walker, and the queue status.
// No dependencies.
`default_nettype none

package lr_pkg;

   // Grid edge length; coordinates beyond GRID_SIZE-1 are saturated.
   localparam int GRID_SIZE = 64;

   // Coordinate width, fixed by the port fields.
   localparam int COORD_W = 6;
   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

   // Error counters and their sums stay between -span and +span.
   localparam int ERR_W = COORD_W + 2;

   // Descriptor queue depth (a power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream widths.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] abs_dx;
      logic [COORD_W-1:0] abs_dy;
      logic [COORD_W-1:0] span;
      logic               neg_x;
      logic               neg_y;
   } line_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
      logic [COORD_W-1:0] r;
      r = (c > COORD_MAX) ? COORD_MAX : c;
      return r;
   endfunction

endpackage : lr_pkg

`default_nettype wire

// ----- rtl/lr_front.sv -----
// Front end of the line rasterizer: takes request beats, saturates the
// endpoints and works out deltas, directions and span. Uses lr_pkg.
`default_nettype none

module lr_front
   import lr_pkg::*;
(
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // start_x, start_y, end_x, end_y
   input  wire queue_status_type      q_status,
   output logic                       push,
   output line_desc_type              push_desc
);

   logic [COORD_W-1:0] sx, sy, ex, ey;
   logic [COORD_W-1:0] adx, ady;

   always_comb begin
      sx = clamp_coord(req_tdata[COORD_W-1:0]);
      sy = clamp_coord(req_tdata[2*COORD_W-1:COORD_W]);
      ex = clamp_coord(req_tdata[3*COORD_W-1:2*COORD_W]);
      ey = clamp_coord(req_tdata[4*COORD_W-1:3*COORD_W]);

      adx = (ex >= sx) ? (ex - sx) : (sx - ex);
      ady = (ey >= sy) ? (ey - sy) : (sy - ey);

      push_desc.start_x = sx;
      push_desc.start_y = sy;
      push_desc.abs_dx  = adx;
      push_desc.abs_dy  = ady;
      push_desc.span    = (adx > ady) ? adx : ady;
      push_desc.neg_x   = (ex < sx);
      push_desc.neg_y   = (ey < sy);
   end

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && !q_status.full;

endmodule : lr_front

`default_nettype wire

// ----- rtl/lr_queue.sv -----
// Small descriptor queue between the front end and the walker.
// Uses lr_pkg for the descriptor type and depth.
`default_nettype none

module lr_queue
   import lr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire line_desc_type push_desc,
   input  wire logic          pop,
   output line_desc_type      head_desc,
   output queue_status_type   q_status
);

   line_desc_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head_desc      = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule : lr_queue

`default_nettype wire

// ----- rtl/lr_walker.sv -----
// Line rasterizer back end (uses lr_pkg): steps along one line with two error
// counters, a point per cycle into the response register unless it stalls.
`default_nettype none

module lr_walker
   import lr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire line_desc_type         head_desc,
   input  wire queue_status_type      q_status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // point_x, point_y, zero pad
   output logic                       rsp_tlast    // last_point
);

   logic                      active_ff,  active_in;
   line_desc_type             desc_ff,    desc_in;
   logic [COORD_W-1:0]        px_ff,      px_in;
   logic [COORD_W-1:0]        py_ff,      py_in;
   logic signed [ERR_W-1:0]   errx_ff,    errx_in;
   logic signed [ERR_W-1:0]   erry_ff,    erry_in;
   logic [COORD_W-1:0]        remain_ff,  remain_in;
   logic                      out_vld_ff, out_vld_in;
   logic [COORD_W-1:0]        out_x_ff,   out_x_in;
   logic [COORD_W-1:0]        out_y_ff,   out_y_in;
   logic                      out_last_ff, out_last_in;

   logic                      emit;
   logic signed [ERR_W-1:0]   err_init;
   logic signed [ERR_W-1:0]   sum_x, sum_y, span_s;

   always_comb begin
      pop  = !active_ff && !q_status.empty;
      emit = active_ff && (!out_vld_ff || rsp_tready);

      // Both counters start at minus half the span, rounded toward zero.
      err_init = -signed'({{(ERR_W-COORD_W+1){1'b0}}, head_desc.span[COORD_W-1:1]});
      span_s   = signed'({{(ERR_W-COORD_W){1'b0}}, desc_ff.span});
      sum_x    = errx_ff + signed'({{(ERR_W-COORD_W){1'b0}}, desc_ff.abs_dx});
      sum_y    = erry_ff + signed'({{(ERR_W-COORD_W){1'b0}}, desc_ff.abs_dy});

      active_in   = active_ff;
      desc_in     = desc_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      errx_in     = errx_ff;
      erry_in     = erry_ff;
      remain_in   = remain_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_last_in = out_last_ff;

      if (pop) begin
         active_in = 1'b1;
         desc_in   = head_desc;
         px_in     = head_desc.start_x;
         py_in     = head_desc.start_y;
         errx_in   = err_init;
         erry_in   = err_init;
         remain_in = head_desc.span;
      end

      if (emit) begin
         out_vld_in  = 1'b1;
         out_x_in    = px_ff;
         out_y_in    = py_ff;
         out_last_in = (remain_ff == '0);
         if (remain_ff == '0) begin
            active_in = 1'b0;
         end else begin
            remain_in = remain_ff - COORD_W'(1);
            // A counter that rises above zero moves its coordinate and
            // falls back by the span.
            if (sum_x > 0) begin
               errx_in = sum_x - span_s;
               px_in   = desc_ff.neg_x ? px_ff - COORD_W'(1) : px_ff + COORD_W'(1);
            end else begin
               errx_in = sum_x;
            end
            if (sum_y > 0) begin
               erry_in = sum_y - span_s;
               py_in   = desc_ff.neg_y ? py_ff - COORD_W'(1) : py_ff + COORD_W'(1);
            end else begin
               erry_in = sum_y;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      errx_ff     <= errx_in;
      erry_ff     <= erry_in;
      remain_ff   <= remain_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*COORD_W){1'b0}}, out_y_ff, out_x_ff};
   assign rsp_tlast  = out_last_ff;

endmodule : lr_walker

`default_nettype wire

// ----- rtl/line_rasterizer.sv -----
// Line rasterizer: takes two endpoints on a square grid and streams out every
// grid point of the line between them, start first and end last, the final
// point marked by tlast. A line of N = max(|dx|,|dy|)+1 points gives N
// response beats, one per cycle within a line while the consumer is ready;
// between lines the walker loads the next line and emits no beat, as all
// lines pass through its single stepping loop. Each accepted line is written
// into the queue, loaded into the walker's registers once the walker is free,
// and its first point then goes to the response register. A two-entry queue
// holds accepted lines, so request beats are taken while a line is still
// being walked. Endpoint coordinates beyond the grid edge are saturated to
// the edge. No state survives between lines.
//
// Files: lr_pkg (constants, types), lr_front, lr_queue, lr_walker.
`default_nettype none

module line_rasterizer
   import lr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // Request stream: one beat per line.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [5:0] start_x, [11:6] start_y,
                                                   // [17:12] end_x, [23:18] end_y

   // Response stream: one beat per line point.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [5:0] point_x, [11:6] point_y,
                                                   // [15:12] zero
   output logic                       rsp_tlast    // last_point
);

   queue_status_type q_status;
   line_desc_type    push_desc;
   line_desc_type    head_desc;
   logic             push;
   logic             pop;

   // The front end classifies each request beat in the cycle it arrives.
   lr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_desc  (push_desc)
   );

   // Lines wait here until the walker is free.
   lr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .q_status  (q_status)
   );

   // The walker produces one point per cycle into the response register unless it stalls.
   lr_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .head_desc  (head_desc),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule : line_rasterizer

`default_nettype wire

// ----- rtl/lr_checker.sv -----
// Port checker for the line rasterizer, bound to the top level.
// Sees the top-level ports only; no package dependency.
`default_nettype none

module lr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   logic       mid_ff, mid_in;
   logic [5:0] prev_x_ff, prev_x_in;
   logic [5:0] prev_y_ff, prev_y_in;
   logic       rsp_beat;
   logic [5:0] step_x, step_y;
   logic       near_x, near_y, adjacent;

   always_comb begin
      rsp_beat  = rsp_tvalid && rsp_tready;
      mid_in    = rsp_beat ? !rsp_tlast : mid_ff;
      prev_x_in = rsp_beat ? rsp_tdata[5:0]  : prev_x_ff;
      prev_y_in = rsp_beat ? rsp_tdata[11:6] : prev_y_ff;
      step_x    = rsp_tdata[5:0]  - prev_x_ff;
      step_y    = rsp_tdata[11:6] - prev_y_ff;
      near_x    = (step_x == 6'd0) || (step_x == 6'd1) || (step_x == 6'h3f);
      near_y    = (step_y == 6'd0) || (step_y == 6'd1) || (step_y == 6'h3f);
      adjacent  = near_x && near_y && !((step_x == 6'd0) && (step_y == 6'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
      end else begin
         mid_ff <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
   end

   // A stalled request beat stays on the bus until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request beat changed while stalled");

   // A stalled response beat keeps its point and its last flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   // Nothing is presented in the cycle after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // Within one line, each point is a grid neighbor of the one before it.
   a_rsp_adjacent: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && mid_ff |-> adjacent)
      else $error("line point is not a neighbor of the previous point");

   // The padding above the two coordinates stays zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:12] == 4'd0)
      else $error("response padding bits not zero");

endmodule : lr_checker

bind line_rasterizer lr_checker u_lr_checker (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for line_rasterizer: line requests in, one beat per line point out.
// It predicts every point with its own stepping walker and needs only lr_pkg and the block.
`timescale 1ns / 100ps

module testbench;
   import lr_pkg::*;

   // One line request, packed so that it matches the request tdata layout.
   typedef struct packed {
      logic [COORD_W-1:0] end_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] start_x;
   } line_req_type;

   // One line point as the response stream carries it.
   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } line_point_type;

   localparam int RANDOM_LINES = 450;
   // Once this few lines are left to send, no new idle bursts start on either side.
   localparam int CALM_TAIL    = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [5:0] start_x, [11:6] start_y,
                                            // [17:12] end_x, [23:18] end_y
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [5:0] point_x, [11:6] point_y, [15:12] zero
   logic                  rsp_tlast;        // last_point

   line_req_type   lines_to_send[$];
   line_point_type pending_points[$];

   int fault_count = 0;
   int lines_sent  = 0;
   int points_seen = 0;
   int req_gap     = 0;
   int rsp_gap     = 0;
   // Chance in percent that a burst of idle cycles starts; it changes as the run goes on,
   // so some stretches have no idling at all.
   int stall_pct   = 30;

   line_rasterizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Coordinates past the grid edge are pulled back to the edge before the walk.
   function automatic int fit_grid(input logic [COORD_W-1:0] c);
      int v;
      v = int'(c);
      if (v > GRID_SIZE - 1) v = GRID_SIZE - 1;
      return v;
   endfunction

   // Walks the line the same way the block does and queues every point it must emit.
   // Both axes share one span; each axis error starts at -span/2 and steps the
   // coordinate whenever it climbs above zero.
   function automatic void rasterize_line(input line_req_type ln);
      int             sx, sy, ex, ey;
      int             adx, ady, span, errx, erry, px, py, i;
      line_point_type pt;
      sx   = fit_grid(ln.start_x);
      sy   = fit_grid(ln.start_y);
      ex   = fit_grid(ln.end_x);
      ey   = fit_grid(ln.end_y);
      adx  = (ex >= sx) ? ex - sx : sx - ex;
      ady  = (ey >= sy) ? ey - sy : sy - ey;
      span = (adx > ady) ? adx : ady;
      errx = -(span / 2);
      erry = errx;
      px   = sx;
      py   = sy;
      for (i = 0; i <= span; i++) begin
         if (i > 0) begin
            errx += adx;
            if (errx > 0) begin
               px   += (ex > sx) ? 1 : -1;
               errx -= span;
            end
            erry += ady;
            if (erry > 0) begin
               py   += (ey > sy) ? 1 : -1;
               erry -= span;
            end
         end
         pt.x    = COORD_W'(px);
         pt.y    = COORD_W'(py);
         pt.last = (i == span);
         pending_points.insert(pending_points.size(), pt);
      end
   endfunction

   task automatic add_line(input int sx, input int sy, input int ex, input int ey);
      line_req_type ln;
      ln.start_x = COORD_W'(sx);
      ln.start_y = COORD_W'(sy);
      ln.end_x   = COORD_W'(ex);
      ln.end_y   = COORD_W'(ey);
      lines_to_send.insert(lines_to_send.size(), ln);
   endtask

   // A coordinate a few steps away from c, kept on the grid.
   function automatic int near_coord(input int c);
      int v;
      v = c + $urandom_range(0, 8) - 4;
      if (v < 0) v = 0;
      if (v > GRID_SIZE - 1) v = GRID_SIZE - 1;
      return v;
   endfunction

   // Request driver. The beat on the bus stays put while tvalid is high and tready is low.
   // After each accepted beat the expected points of that line are queued, and now and
   // then a burst of idle cycles is put in before the next beat.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rasterize_line(lines_to_send[0]);
            void'(lines_to_send.pop_front());
            lines_sent++;
            if (lines_sent % 50 == 0) begin
               case ($urandom_range(0, 2))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  default: stall_pct = 60;
               endcase
            end
            if (lines_to_send.size() > CALM_TAIL && $urandom_range(0, 99) < stall_pct)
               req_gap = $urandom_range(1, 6);
         end
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (lines_to_send.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= lines_to_send[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every accepted point beat is checked against the oldest expected
   // point; tready drops in random bursts while the run is not in its tail.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            points_seen++;
            if (pending_points.size() == 0) begin
               $display("%0t: point beat with nothing expected, got x=%0d y=%0d last=%0b",
                        $time, rsp_tdata[5:0], rsp_tdata[11:6], rsp_tlast);
               fault_count++;
            end else begin
               if (rsp_tdata[5:0] !== pending_points[0].x ||
                   rsp_tdata[11:6] !== pending_points[0].y ||
                   rsp_tlast !== pending_points[0].last) begin
                  $display("%0t: mismatch, expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                           $time, pending_points[0].x, pending_points[0].y,
                           pending_points[0].last, rsp_tdata[5:0], rsp_tdata[11:6],
                           rsp_tlast);
                  fault_count++;
               end
               void'(pending_points.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (lines_to_send.size() > CALM_TAIL && $urandom_range(0, 99) < stall_pct)
               rsp_gap = $urandom_range(1, 6);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int k, sx, sy;

      // Zero-length lines at both corners of the grid.
      add_line(0, 0, 0, 0);
      add_line(63, 63, 63, 63);
      // Full-length horizontal and vertical lines in both directions.
      add_line(0, 0, 63, 0);
      add_line(63, 0, 0, 0);
      add_line(0, 0, 0, 63);
      add_line(5, 63, 5, 0);
      // The four full diagonals.
      add_line(0, 0, 63, 63);
      add_line(63, 0, 0, 63);
      add_line(0, 63, 63, 0);
      add_line(63, 63, 0, 0);
      // Nearly flat and nearly steep lines: one axis steps once over a long span.
      add_line(0, 0, 63, 1);
      add_line(0, 0, 1, 63);
      add_line(63, 62, 0, 63);
      // Odd and even spans, where the starting error differs.
      add_line(10, 10, 13, 11);
      add_line(10, 10, 14, 11);
      add_line(30, 40, 25, 37);
      // Single steps along +x, along -y, and diagonally (-x, +y).
      add_line(20, 20, 21, 20);
      add_line(20, 20, 19, 21);
      add_line(20, 20, 20, 19);
      // Alternating bit patterns on every coordinate.
      add_line(42, 21, 21, 42);
      add_line(21, 42, 42, 21);

      for (k = 0; k < RANDOM_LINES; k++) begin
         sx = $urandom_range(0, GRID_SIZE - 1);
         sy = $urandom_range(0, GRID_SIZE - 1);
         case ($urandom_range(0, 9))
            0:       add_line(sx, sy, sx, sy);
            1, 2, 3: add_line(sx, sy, near_coord(sx), near_coord(sy));
            4:       add_line(sx, sy, $urandom_range(0, GRID_SIZE - 1), sy);
            5:       add_line(sx, sy, sx, $urandom_range(0, GRID_SIZE - 1));
            default: add_line(sx, sy, $urandom_range(0, GRID_SIZE - 1),
                              $urandom_range(0, GRID_SIZE - 1));
         endcase
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (lines_to_send.size() > 0 || pending_points.size() > 0) @(posedge clock);
      // The walker loads each line before walking it; give any stray beat time to show up.
      repeat (80) @(posedge clock);

      $display("Sent %0d lines (directed and random, zero-length up to full grid span);",
               lines_sent);
      $display("checked %0d point beats under random stalls on both sides.", points_seen);
      if (fault_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Far beyond the slowest correct run: every line at 64 points with every beat stalled.
   initial begin
      #12_000_000;
      $display("Timeout with %0d lines left and %0d points outstanding.",
               lines_to_send.size(), pending_points.size());
      $display("Verification failed");
      $finish;
   end

endmodule
